[rtl/core/sort_rows_by_row_sum_defines.svh]
// Assertion macros shared by the RTL of the row sort block.
// They sample on clk_i and stay quiet while rst_ni is low.
`ifndef SORT_ROWS_BY_ROW_SUM_DEFINES_SVH
`define SORT_ROWS_BY_ROW_SUM_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SRRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Check that cons holds in the cycle after ante.
`define SRRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[rtl/core/srrs_pkg.sv]
package srrs_pkg;

  // Command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_SORT  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Result kinds
  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_SORTED = 1'b1;

  // Element width (Q7.8)
  localparam int ELEM_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0]  CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_NUM_COLS = 2'd1;
  localparam logic [CFG_DATA_W-1:0] DIM_RST      = 5'd16;

  typedef struct packed {
    logic [1:0]               command;
    logic [3:0]               row;
    logic [3:0]               col;
    logic signed [ELEM_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                     kind;
    logic signed [ELEM_W-1:0] data;
  } res_t;

endpackage

[rtl/core/sort_rows_by_row_sum.sv]
// Matrix store with row sort by row sum.
// Commands enter on start/cmd_i and are taken when busy is low.
// A write (command 0) stores one element at a logical (row, col); the block stays busy
// until the write is done, so a new command waits for it.
// A read (command 2) returns one element; it passes through ST_CMD_ORD and ST_RD_ELEM,
// and the result word shows on res_o with res_strobe_o in the first idle cycle.
// A sort (command 1) reorders the first num_rows rows by ascending row sum and
// then shows one word with kind 1 and data 0. It first sums every row in use, one
// element per cycle from the element memory, then runs exchange passes over the row
// order memory, one compare per cycle. Each memory has a single read port. The
// result word shows in the first idle cycle.
// Command 3 is taken and dropped.
// Results are strobed for one cycle and the receiver cannot hold them off.
// num_rows and num_cols are written on the cfg channel (always ready); the user must
// write them only while idle, the block does not enforce it. Reset restores the identity
// row order and both sizes to 16; elements are undefined until written.
`include "sort_rows_by_row_sum_defines.svh"

module sort_rows_by_row_sum #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  srrs_pkg::cmd_t                     cmd_i,
  output logic                               res_strobe_o,
  output srrs_pkg::res_t                     res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [srrs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [srrs_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import srrs_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int NW    = $clog2(MAX_ROWS + 1);
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int EAW   = $clog2(MAX_ROWS * MAX_COLS);
  localparam int ELEMS = MAX_ROWS * MAX_COLS;
  localparam int SW    = ELEM_W + 1 + $clog2(MAX_COLS);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_CMD_ORD = 10'b0000000010,
    ST_RD_ELEM = 10'b0000000100,
    ST_SUM_ORD = 10'b0000001000,
    ST_SUM_PH  = 10'b0000010000,
    ST_SUM_ACC = 10'b0000100000,
    ST_LAST_RD = 10'b0001000000,
    ST_LAST_LD = 10'b0010000000,
    ST_CMP     = 10'b0100000000,
    ST_LAST_WR = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] num_rows_q, num_cols_q;
  logic [NW-1:0]         nr_eff;
  logic [CNW-1:0]        nc_eff;

  cmd_t                  cmd_q, cmd_d;
  logic                  in_range_q, in_range_d, in_range_i;
  logic [RW-1:0]         phys_q, phys_d;
  logic signed [SW-1:0]  acc_q, acc_d, sum_next, elem_ext;
  logic [CNW-1:0]        c_q, c_d;
  logic [NW-1:0]         r_q, r_d, r_inc, r_dec;
  logic [RW-1:0]         i_q, i_d;
  logic [NW-1:0]         i_inc_w;
  logic [RW-1:0]         cur_phys_q, cur_phys_d;
  logic signed [SW-1:0]  cur_sum_q, cur_sum_d;
  logic                  res_strobe_q, res_strobe_d;
  res_t                  res_q, res_d;

  logic [RW-1:0]         ord_raddr, ord_rphys, ord_waddr, ord_wphys;
  logic signed [SW-1:0]  ord_rsum, ord_wsum;
  logic                  ord_we;

  logic [ELEM_W-1:0]     elem_mem [ELEMS];
  logic [ELEM_W-1:0]     elem_rdata_q;
  logic [EAW-1:0]        elem_addr;
  logic                  elem_we;

  function automatic logic [EAW-1:0] elem_addr_f(input logic [RW-1:0] phys,
                                                 input logic [31:0] col);
    return EAW'(32'(phys) * MAX_COLS + col);
  endfunction

  // Clamp the size registers to the storage; a zero size counts as one
  always_comb begin
    if (num_rows_q == '0) begin
      nr_eff = NW'(1);
    end else if (32'(num_rows_q) > MAX_ROWS) begin
      nr_eff = NW'(MAX_ROWS);
    end else begin
      nr_eff = NW'(num_rows_q);
    end
    if (num_cols_q == '0) begin
      nc_eff = CNW'(1);
    end else if (32'(num_cols_q) > MAX_COLS) begin
      nc_eff = CNW'(MAX_COLS);
    end else begin
      nc_eff = CNW'(num_cols_q);
    end
  end

  assign in_range_i = (32'(cmd_i.row) < MAX_ROWS) && (32'(cmd_i.col) < MAX_COLS);
  assign elem_ext   = {{(SW-ELEM_W){elem_rdata_q[ELEM_W-1]}}, elem_rdata_q};
  assign sum_next   = acc_q + elem_ext;
  assign r_inc      = r_q + NW'(1);
  assign r_dec      = r_q - NW'(1);
  assign i_inc_w    = NW'(i_q) + NW'(1);

  // Row order memory with per-row sums
  srrs_order_mem #(
    .MAX_ROWS (MAX_ROWS),
    .SUM_W    (SW)
  ) u_order (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (ord_raddr),
    .rd_phys_o (ord_rphys),
    .rd_sum_o  (ord_rsum),
    .wr_en_i   (ord_we),
    .wr_addr_i (ord_waddr),
    .wr_phys_i (ord_wphys),
    .wr_sum_i  (ord_wsum)
  );

  // Element memory, one access a cycle
  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[elem_addr] <= cmd_q.value;
    end
    elem_rdata_q <= elem_mem[elem_addr];
  end

  // Sequence commands and the sort
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    in_range_d   = in_range_q;
    phys_d       = phys_q;
    acc_d        = acc_q;
    c_d          = c_q;
    r_d          = r_q;
    i_d          = i_q;
    cur_phys_d   = cur_phys_q;
    cur_sum_d    = cur_sum_q;
    res_strobe_d = 1'b0;
    res_d        = res_q;
    ord_raddr    = '0;
    ord_we       = 1'b0;
    ord_waddr    = '0;
    ord_wphys    = cur_phys_q;
    ord_wsum     = cur_sum_q;
    elem_we      = 1'b0;
    elem_addr    = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d      = cmd_i;
          in_range_d = in_range_i;
          ord_raddr  = RW'(cmd_i.row);
          if ((cmd_i.command == CMD_WRITE) || (cmd_i.command == CMD_READ)) begin
            state_d = ST_CMD_ORD;
          end else if (cmd_i.command == CMD_SORT) begin
            r_d     = '0;
            state_d = ST_SUM_ORD;
          end
        end
      end
      ST_CMD_ORD: begin
        elem_addr = elem_addr_f(ord_rphys, 32'(cmd_q.col));
        if (cmd_q.command == CMD_WRITE) begin
          elem_we = in_range_q;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_RD_ELEM;
        end
      end
      ST_RD_ELEM: begin
        res_strobe_d = 1'b1;
        res_d.kind   = KIND_READ;
        res_d.data   = in_range_q ? signed'(elem_rdata_q) : '0;
        state_d      = ST_IDLE;
      end
      ST_SUM_ORD: begin
        ord_raddr = r_q[RW-1:0];
        state_d   = ST_SUM_PH;
      end
      ST_SUM_PH: begin
        phys_d    = ord_rphys;
        elem_addr = elem_addr_f(ord_rphys, 32'd0);
        c_d       = '0;
        acc_d     = '0;
        state_d   = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        if (c_q == nc_eff - CNW'(1)) begin
          // store the finished sum with its row
          ord_we    = 1'b1;
          ord_waddr = r_q[RW-1:0];
          ord_wphys = phys_q;
          ord_wsum  = sum_next;
          r_d       = r_inc;
          if (r_inc == nr_eff) begin
            if (nr_eff == NW'(1)) begin
              res_strobe_d = 1'b1;
              res_d.kind   = KIND_SORTED;
              res_d.data   = '0;
              state_d      = ST_IDLE;
            end else begin
              r_d     = nr_eff - NW'(1);
              state_d = ST_LAST_RD;
            end
          end else begin
            state_d = ST_SUM_ORD;
          end
        end else begin
          acc_d     = sum_next;
          c_d       = c_q + CNW'(1);
          elem_addr = elem_addr_f(phys_q, 32'(c_q) + 32'd1);
        end
      end
      ST_LAST_RD: begin
        ord_raddr = r_q[RW-1:0];
        state_d   = ST_LAST_LD;
      end
      ST_LAST_LD: begin
        // hold the row at the last position in registers for the pass
        cur_phys_d = ord_rphys;
        cur_sum_d  = ord_rsum;
        i_d        = '0;
        ord_raddr  = '0;
        state_d    = ST_CMP;
      end
      ST_CMP: begin
        if (ord_rsum > cur_sum_q) begin
          ord_we     = 1'b1;
          ord_waddr  = i_q;
          cur_phys_d = ord_rphys;
          cur_sum_d  = ord_rsum;
        end
        if (i_inc_w == r_q) begin
          state_d = ST_LAST_WR;
        end else begin
          i_d       = i_q + RW'(1);
          ord_raddr = i_q + RW'(1);
        end
      end
      ST_LAST_WR: begin
        ord_we    = 1'b1;
        ord_waddr = r_q[RW-1:0];
        r_d       = r_dec;
        if (r_q == NW'(1)) begin
          res_strobe_d = 1'b1;
          res_d.kind   = KIND_SORTED;
          res_d.data   = '0;
          state_d      = ST_IDLE;
        end else begin
          ord_raddr = r_dec[RW-1:0];
          state_d   = ST_LAST_LD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      res_strobe_q <= 1'b0;
      c_q          <= '0;
      r_q          <= '0;
      i_q          <= '0;
      num_rows_q   <= DIM_RST;
      num_cols_q   <= DIM_RST;
    end else begin
      state_q      <= state_d;
      res_strobe_q <= res_strobe_d;
      c_q          <= c_d;
      r_q          <= r_d;
      i_q          <= i_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_NUM_ROWS: num_rows_q <= cfg_data_i;
          CFG_NUM_COLS: num_cols_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    in_range_q <= in_range_d;
    phys_q     <= phys_d;
    acc_q      <= acc_d;
    cur_phys_q <= cur_phys_d;
    cur_sum_q  <= cur_sum_d;
    res_q      <= res_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;
  assign cfg_ready_o  = 1'b1;

  `SRRS_ASSERT_NEXT(a_strobe_single, res_strobe_o, !res_strobe_o)
  `SRRS_ASSERT_IMP(a_sorted_zero, res_strobe_o && (res_o.kind == KIND_SORTED), res_o.data == '0)
  `SRRS_ASSERT_NEXT(a_sort_busy, start && !busy && (cmd_i.command == CMD_SORT), busy)
  `SRRS_ASSERT_IMP(a_order_wr_busy, ord_we, busy)

endmodule

[rtl/core/srrs_order_mem.sv]
module srrs_order_mem #(
  parameter int MAX_ROWS = 16,
  parameter int SUM_W    = 21,
  localparam int RW      = $clog2(MAX_ROWS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [RW-1:0]           rd_addr_i,
  output logic [RW-1:0]           rd_phys_o,
  output logic signed [SUM_W-1:0] rd_sum_o,
  input  logic                    wr_en_i,
  input  logic [RW-1:0]           wr_addr_i,
  input  logic [RW-1:0]           wr_phys_i,
  input  logic signed [SUM_W-1:0] wr_sum_i
);

  logic [RW+SUM_W-1:0] mem [MAX_ROWS];
  logic [RW+SUM_W-1:0] rdata_q;
  logic [RW-1:0]       rd_addr_q;
  logic [MAX_ROWS-1:0] valid_q;
  logic                rd_valid_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_phys_i, wr_sum_i};
    end
    rdata_q   <= mem[rd_addr_i];
    rd_addr_q <= rd_addr_i;
  end

  // Track written entries; an unwritten entry holds its own row and a zero sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_phys_o = rd_valid_q ? rdata_q[RW+SUM_W-1:SUM_W] : rd_addr_q;
  assign rd_sum_o  = rd_valid_q ? signed'(rdata_q[SUM_W-1:0]) : '0;

endmodule

[tb/row_sort_checker.sv]
`timescale 1ns / 1ps

// Watches the command, result and register channels of the row sort block,
// keeps its own copy of the matrix and the row order, and compares every
// result word with the oldest word it expects.
module row_sort_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  srrs_pkg::cmd_t                      cmd_i,
  input  logic                                res_strobe_i,
  input  srrs_pkg::res_t                      res_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [srrs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [srrs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output int                                  mismatch_count_o,
  output int                                  pending_o
);

  localparam int ROWS  = 16;
  localparam int COLS  = 16;
  localparam int SUM_W = 21;

  // Matrix by physical row, sums by physical row, logical-to-physical map
  logic signed [srrs_pkg::ELEM_W-1:0] elem_mem [ROWS][COLS];
  logic signed [SUM_W-1:0]            row_total [ROWS];
  logic [3:0]                         row_map [ROWS];
  logic [srrs_pkg::CFG_DATA_W-1:0]    rows_cfg;
  logic [srrs_pkg::CFG_DATA_W-1:0]    cols_cfg;
  srrs_pkg::res_t                     expected_words [$];
  int                                 mismatches = 0;
  int                                 pending_n  = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending_n;

  // Map a register code onto the size actually used
  function automatic int dim_in_use(logic [srrs_pkg::CFG_DATA_W-1:0] code, int maxv);
    if (code == 0) return 1;
    if (code > maxv) return maxv;
    return int'(code);
  endfunction

  // Sum the rows in use, then run the exchange passes from the last position down
  function automatic void sort_by_total();
    int                      nr;
    int                      nc;
    logic [3:0]              phys;
    logic [3:0]              held;
    logic signed [SUM_W-1:0] acc;
    nr = dim_in_use(rows_cfg, ROWS);
    nc = dim_in_use(cols_cfg, COLS);
    for (int r = 0; r < nr; r++) begin
      phys = row_map[r];
      acc  = '0;
      for (int c = 0; c < nc; c++) acc += elem_mem[phys][c];
      row_total[phys] = acc;
    end
    for (int last = nr - 1; last >= 1; last--) begin
      for (int i = 0; i < last; i++) begin
        if (row_total[row_map[i]] > row_total[row_map[last]]) begin
          held          = row_map[i];
          row_map[i]    = row_map[last];
          row_map[last] = held;
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    srrs_pkg::res_t want;
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        row_map[r]   = 4'(r);
        row_total[r] = '0;
        for (int c = 0; c < COLS; c++) elem_mem[r][c] = '0;
      end
      rows_cfg = srrs_pkg::DIM_RST;
      cols_cfg = srrs_pkg::DIM_RST;
      expected_words.delete();
    end else begin
      // Compare a result word with the oldest expectation
      if (res_strobe_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, got kind %0d data %0d",
                   $time, res_i.kind, res_i.data);
        end else begin
          want = expected_words.pop_front();
          if (res_i.kind !== want.kind) begin
            mismatches++;
            $display("%0t: kind mismatch, expected %0d, got %0d",
                     $time, want.kind, res_i.kind);
          end
          if (res_i.data !== want.data) begin
            mismatches++;
            $display("%0t: data mismatch, expected %0d, got %0d",
                     $time, want.data, res_i.data);
          end
        end
      end

      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          srrs_pkg::CFG_NUM_ROWS: rows_cfg = cfg_data_i;
          srrs_pkg::CFG_NUM_COLS: cols_cfg = cfg_data_i;
          default: ;
        endcase
      end

      // Predict the effect of an accepted command word
      if (start_i && !busy_i) begin
        case (cmd_i.command)
          srrs_pkg::CMD_WRITE: elem_mem[row_map[cmd_i.row]][cmd_i.col] = cmd_i.value;
          srrs_pkg::CMD_SORT: begin
            sort_by_total();
            want.kind = srrs_pkg::KIND_SORTED;
            want.data = '0;
            expected_words.push_back(want);
          end
          srrs_pkg::CMD_READ: begin
            want.kind = srrs_pkg::KIND_READ;
            want.data = elem_mem[row_map[cmd_i.row]][cmd_i.col];
            expected_words.push_back(want);
          end
          default: ;
        endcase
      end
    end
    pending_n = expected_words.size();
  end

endmodule

[tb/tb_sort_rows_by_row_sum.sv]
`timescale 1ns / 1ps

module tb_sort_rows_by_row_sum;

  // Command 3 is taken and dropped; index 3 holds no register
  localparam logic [1:0]                     CMD_NOP   = 2'd3;
  localparam logic [srrs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int                             RESULT_DRAIN_CYCLES = 2000;

  logic                              clk_i = 1'b0;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  srrs_pkg::cmd_t                    cmd_word;
  logic                              res_strobe;
  srrs_pkg::res_t                    res_word;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [srrs_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [srrs_pkg::CFG_DATA_W-1:0]   cfg_data;
  int                                mismatches;
  int                                pending;
  bit                                steady;

  always #10 clk_i = ~clk_i;

  sort_rows_by_row_sum dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_word),
    .res_strobe_o (res_strobe),
    .res_o        (res_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  row_sort_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .cmd_i            (cmd_word),
    .res_strobe_i     (res_strobe),
    .res_i            (res_word),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // Mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Element value with the extremes mixed in
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Register code: mostly small sizes, some full size and out of range codes
  function automatic logic [4:0] pick_dim_code();
    case ($urandom_range(0, 9))
      0: return 5'd16;
      1: return 5'd0;
      2: return 5'($urandom_range(17, 31));
      3: return 5'($urandom_range(7, 15));
      default: return 5'($urandom_range(1, 6));
    endcase
  endfunction

  // Present one command word and hold it until the block takes it
  task automatic send_word(logic [1:0] op, int r, int c, logic signed [15:0] v);
    int             gap;
    srrs_pkg::cmd_t word;
    gap          = pick_gap();
    word.command = op;
    word.row     = 4'(r);
    word.col     = 4'(c);
    word.value   = v;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start    <= 1'b1;
    cmd_word <= word;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Hold off until every expected word has come and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one register word
  task automatic cfg_write(logic [srrs_pkg::CFG_IDX_W-1:0] idx, logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [4:0] rows_code;
    logic [4:0] cols_code;
    int         rows_used;
    int         cols_used;
    int         roll;
    int         r;
    int         c;
    rst_n     = 1'b0;
    start     = 1'b0;
    cmd_word  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // Fill the whole matrix so that every later read and sort sees written data
    for (int fr = 0; fr < 16; fr++) begin
      for (int fc = 0; fc < 16; fc++) send_word(srrs_pkg::CMD_WRITE, fr, fc, pick_value());
    end

    // Corners, extremes, full size sort, dropped command
    send_word(srrs_pkg::CMD_READ, 0, 0, '0);
    send_word(srrs_pkg::CMD_READ, 15, 15, '0);
    send_word(srrs_pkg::CMD_WRITE, 0, 0, 16'sh7fff);
    send_word(srrs_pkg::CMD_WRITE, 15, 15, 16'sh8000);
    send_word(srrs_pkg::CMD_WRITE, 15, 0, '1);
    send_word(srrs_pkg::CMD_SORT, 0, 0, '0);
    send_word(srrs_pkg::CMD_READ, 0, 0, '0);
    send_word(srrs_pkg::CMD_READ, 15, 15, '0);
    send_word(srrs_pkg::CMD_READ, 15, 0, '0);
    send_word(CMD_NOP, 15, 15, '1);

    // Equal sums keep their order; a larger first row then moves down.
    // Column 1 lies outside the sum and tells the two rows apart.
    drain();
    cfg_write(srrs_pkg::CFG_NUM_ROWS, 5'd2);
    cfg_write(srrs_pkg::CFG_NUM_COLS, 5'd1);
    send_word(srrs_pkg::CMD_WRITE, 0, 0, 16'sd5);
    send_word(srrs_pkg::CMD_WRITE, 1, 0, 16'sd5);
    send_word(srrs_pkg::CMD_WRITE, 0, 1, 16'sd1);
    send_word(srrs_pkg::CMD_WRITE, 1, 1, 16'sd2);
    send_word(srrs_pkg::CMD_SORT, 0, 0, '0);
    send_word(srrs_pkg::CMD_READ, 0, 1, '0);
    send_word(srrs_pkg::CMD_WRITE, 0, 0, 16'sd9);
    send_word(srrs_pkg::CMD_SORT, 0, 0, '0);
    send_word(srrs_pkg::CMD_READ, 1, 1, '0);

    // Register codes out of range, and a write to an unused index
    drain();
    cfg_write(CFG_SPARE, 5'd31);
    cfg_write(srrs_pkg::CFG_NUM_ROWS, 5'd0);
    cfg_write(srrs_pkg::CFG_NUM_COLS, 5'd31);
    send_word(srrs_pkg::CMD_SORT, 0, 0, '0);
    send_word(srrs_pkg::CMD_READ, 2, 3, '0);
    drain();
    cfg_write(srrs_pkg::CFG_NUM_ROWS, 5'd17);
    cfg_write(srrs_pkg::CFG_NUM_COLS, 5'd0);
    send_word(srrs_pkg::CMD_SORT, 0, 0, '0);
    send_word(srrs_pkg::CMD_READ, 9, 0, '0);

    // Random phases, each with its own matrix size
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      rows_code = pick_dim_code();
      cols_code = pick_dim_code();
      cfg_write(srrs_pkg::CFG_NUM_ROWS, rows_code);
      cfg_write(srrs_pkg::CFG_NUM_COLS, cols_code);
      rows_used = (rows_code == 0) ? 1 : ((rows_code > 16) ? 16 : int'(rows_code));
      cols_used = (cols_code == 0) ? 1 : ((cols_code > 16) ? 16 : int'(cols_code));
      steady    = (phase % 3 == 1);
      repeat (42) begin
        roll = $urandom_range(0, 99);
        r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, rows_used - 1);
        c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, cols_used - 1);
        if (roll < 45) send_word(srrs_pkg::CMD_WRITE, r, c, pick_value());
        else if (roll < 85) send_word(srrs_pkg::CMD_READ, r, c, pick_value());
        else if (roll < 95) send_word(srrs_pkg::CMD_SORT, r, c, pick_value());
        else send_word(CMD_NOP, r, c, pick_value());
      end
    end
    steady = 1'b0;

    // Let the last words come out, then give the verdict
    start <= 1'b0;
    for (int k = 0; k < RESULT_DRAIN_CYCLES && (pending != 0 || busy); k++) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sort_rows_by_row_sum.f]
+incdir+rtl/core
rtl/core/srrs_pkg.sv
rtl/core/srrs_order_mem.sv
rtl/core/sort_rows_by_row_sum.sv
tb/row_sort_checker.sv
tb/tb_sort_rows_by_row_sum.sv
